// ===== rtl/core/rsenc_pkg.sv =====
`default_nettype none
package rsenc_pkg;

  // Field polynomial x^8+x^4+x^3+x^2+1 without the x^8 term
  localparam logic [7:0] GF_POLY_LOW = 8'h1D;

  localparam int MAX_PARITY_DEF = 16;
  // Largest generator degree the coefficient function can build
  localparam int GEN_MAX = 32;

  localparam int QDEPTH = 2;

  localparam logic [1:0] MODE_255_239 = 2'd0;
  localparam logic [1:0] MODE_224_216 = 2'd1;
  localparam logic [1:0] MODE_56_48   = 2'd2;
  localparam logic [1:0] MODE_52_44   = 2'd3;

  localparam logic [7:0] CODE_LEN [4] = '{8'd255, 8'd224, 8'd56, 8'd52};
  localparam logic [7:0] DATA_LEN [4] = '{8'd239, 8'd216, 8'd48, 8'd44};

  localparam logic [2:0] REG_RATE_MODE = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } q_entry_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    acc = '0;
    x   = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = {1'b0, x[7:0] ^ GF_POLY_LOW};
      end
    end
    return acc;
  endfunction

  // Coefficient idx of the generator with roots alpha^1 .. alpha^p
  function automatic logic [7:0] gen_coef(input int p, input int idx);
    logic [7:0] g [GEN_MAX+1];
    logic [7:0] root;
    root = 8'd1;
    for (int k = 0; k <= GEN_MAX; k++) begin
      g[k] = '0;
    end
    g[0] = 8'd1;
    for (int i = 1; i <= p; i++) begin
      root = gf_mul(root, 8'd2);
      for (int j = i; j >= 1; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g[idx];
  endfunction

  // Parity count of a mode, clamped to the register length
  function automatic int parity_len(input int mode, input int maxp);
    int p;
    p = int'(CODE_LEN[mode]) - int'(DATA_LEN[mode]);
    return (p > maxp) ? maxp : p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rsenc_front.sv =====
`default_nettype none
module rsenc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flush,
  input  wire logic [1:0]           mode,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_data,
  output logic                      q_push,
  input  wire logic                 q_ready,
  output rsenc_pkg::q_entry_t       q_entry
);

  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic [7:0] count_inc;
  logic       last;

  assign count_inc = count_r + 8'd1;
  // tag the byte that completes the data part of a codeword
  assign last      = (count_inc == rsenc_pkg::DATA_LEN[mode]);

  assign in_ready      = q_ready;
  assign q_push        = in_valid & q_ready;
  assign q_entry.data  = in_data;
  assign q_entry.last  = last;

  always_comb begin
    count_nxt = count_r;
    if (flush) begin
      count_nxt = '0;
    end else if (q_push) begin
      count_nxt = last ? 8'd0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsenc_fifo.sv =====
`default_nettype none
module rsenc_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flush,
  input  wire logic                 push,
  output logic                      push_ready,
  input  wire rsenc_pkg::q_entry_t  push_entry,
  output logic                      pop_valid,
  input  wire logic                 pop,
  output rsenc_pkg::q_entry_t       pop_entry
);

  localparam int PW = (rsenc_pkg::QDEPTH > 1) ? $clog2(rsenc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(rsenc_pkg::QDEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(rsenc_pkg::QDEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(rsenc_pkg::QDEPTH - 1);

  rsenc_pkg::q_entry_t slot_r [rsenc_pkg::QDEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] wr_nxt;
  logic [PW-1:0] rd_nxt;
  logic [CW-1:0] cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = slot_r[rd_r];
  assign do_push    = push & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (flush) begin
      wr_nxt  = '0;
      rd_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      if (do_push) begin
        wr_nxt = (wr_r == LAST_SLOT) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_nxt = (rd_r == LAST_SLOT) ? '0 : rd_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_nxt = cnt_r + CW'(1);
        2'b01:   cnt_nxt = cnt_r - CW'(1);
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !flush) begin
      slot_r[wr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsenc_back.sv =====
`default_nettype none
module rsenc_back #(
  parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flush,
  input  wire logic [1:0]           mode,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire rsenc_pkg::q_entry_t  q_entry,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_is_parity,
  output logic                      out_end
);

  localparam int P_HI = rsenc_pkg::parity_len(0, MAX_PARITY);
  localparam int P_LO = rsenc_pkg::parity_len(1, MAX_PARITY);
  localparam int PW   = $clog2(MAX_PARITY + 1);

  typedef enum logic {ST_DATA, ST_PARITY} state_t;

  logic [7:0] g_hi [MAX_PARITY];
  logic [7:0] g_lo [MAX_PARITY];

  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_coef
    assign g_hi[j] = rsenc_pkg::gen_coef(P_HI, j);
    assign g_lo[j] = rsenc_pkg::gen_coef(P_LO, j);
  end

  state_t        state_r, state_nxt;
  logic [7:0]    par_r   [MAX_PARITY];
  logic [7:0]    par_nxt [MAX_PARITY];
  logic [PW-1:0] left_r, left_nxt;
  logic          valid_r, valid_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          isp_r, isp_nxt;
  logic          end_r, end_nxt;

  logic          hi;
  logic [7:0]    top;
  logic [7:0]    fb;
  logic          advance;

  assign hi      = (mode == rsenc_pkg::MODE_255_239);
  assign top     = hi ? par_r[P_HI-1] : par_r[P_LO-1];
  assign fb      = q_entry.data ^ top;
  assign advance = !valid_r || out_ready;
  assign q_pop   = (state_r == ST_DATA) && advance && q_valid;

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_is_parity = isp_r;
  assign out_end       = end_r;

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    isp_nxt   = isp_r;
    end_nxt   = end_r;
    for (int j = 0; j < MAX_PARITY; j++) begin
      par_nxt[j] = par_r[j];
    end
    if (flush) begin
      state_nxt = ST_DATA;
      valid_nxt = 1'b0;
      for (int j = 0; j < MAX_PARITY; j++) begin
        par_nxt[j] = '0;
      end
    end else if (advance) begin
      unique case (state_r)
        ST_PARITY: begin
          // emit the highest cell, shift the rest up
          valid_nxt = 1'b1;
          byte_nxt  = top;
          isp_nxt   = 1'b1;
          end_nxt   = (left_r == PW'(1));
          left_nxt  = left_r - PW'(1);
          if (left_r == PW'(1)) begin
            state_nxt = ST_DATA;
          end
          for (int j = 0; j < MAX_PARITY; j++) begin
            if (j < (hi ? P_HI : P_LO) && j > 0) begin
              par_nxt[j] = par_r[j-1];
            end else begin
              par_nxt[j] = '0;
            end
          end
        end
        ST_DATA: begin
          valid_nxt = q_valid;
          if (q_valid) begin
            byte_nxt = q_entry.data;
            isp_nxt  = 1'b0;
            end_nxt  = 1'b0;
            for (int j = 0; j < MAX_PARITY; j++) begin
              if (j < (hi ? P_HI : P_LO)) begin
                par_nxt[j] = ((j > 0) ? par_r[j-1] : 8'd0) ^
                             rsenc_pkg::gf_mul(hi ? g_hi[j] : g_lo[j], fb);
              end else begin
                par_nxt[j] = '0;
              end
            end
            if (q_entry.last) begin
              state_nxt = ST_PARITY;
              left_nxt  = hi ? PW'(P_HI) : PW'(P_LO);
            end
          end
        end
        default: state_nxt = ST_DATA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DATA;
      left_r  <= '0;
      valid_r <= 1'b0;
      byte_r  <= '0;
      isp_r   <= 1'b0;
      end_r   <= 1'b0;
      for (int j = 0; j < MAX_PARITY; j++) begin
        par_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      valid_r <= valid_nxt;
      byte_r  <= byte_nxt;
      isp_r   <= isp_nxt;
      end_r   <= end_nxt;
      for (int j = 0; j < MAX_PARITY; j++) begin
        par_r[j] <= par_nxt[j];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/shortened_rs_gf256_encoder.sv =====
`default_nettype none
// Channel   Direction  Beat contents
// in_       slave      tdata[7:0] = data_byte
// out_      master     tdata[7:0] = out_byte, tuser = is_parity, tlast = codeword_end
// cfg_      APB slave  0x0: rate_mode[1:0]
//
// One beat per cycle in and out while data bytes flow and out_tready is high:
// each byte updates all parity cells at once. After the K-th data byte the
// back end sends P parity bytes (16 or 8) and takes no data meanwhile;
// the two-entry queue fills and in_tready drops during the burst.
// Reset (rst_n, synchronous) clears the parity cells, the byte count and
// rate_mode. A rate_mode write aborts any codeword in progress.
module shortened_rs_gf256_encoder #(
  parameter int MAX_PARITY = rsenc_pkg::MAX_PARITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] data_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // [7:0] out_byte
  output logic             out_tuser,     // [0] is_parity
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [1:0]          mode_r;
  logic [1:0]          mode_nxt;
  logic                wr_mode;
  logic                q_push;
  logic                q_ready;
  logic                q_valid;
  logic                q_pop;
  rsenc_pkg::q_entry_t q_in;
  rsenc_pkg::q_entry_t q_out;

  assign cfg_pready = 1'b1;
  // a rate write also flushes the front count, queue and parity cells
  assign wr_mode    = cfg_psel & cfg_penable & cfg_pwrite &
                      (cfg_paddr == rsenc_pkg::REG_RATE_MODE);
  assign mode_nxt   = wr_mode ? cfg_pwdata[1:0] : mode_r;
  assign cfg_prdata = (cfg_paddr == rsenc_pkg::REG_RATE_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rsenc_pkg::MODE_255_239;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // front: count data bytes, tag the last one of the codeword
  rsenc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (wr_mode),
    .mode     (mode_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_entry  (q_in)
  );

  rsenc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .flush      (wr_mode),
    .push       (q_push),
    .push_ready (q_ready),
    .push_entry (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_out)
  );

  // back: parity LFSR, data echo, parity burst, output register
  rsenc_back #(
    .MAX_PARITY (MAX_PARITY)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .flush         (wr_mode),
    .mode          (mode_r),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_entry       (q_out),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (out_tdata),
    .out_is_parity (out_tuser),
    .out_end       (out_tlast)
  );

endmodule
`default_nettype wire
